// ===== rtl/tccw_pkg.sv =====
package tccw_pkg;

  // Operation codes of an input item
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Character codes with special handling
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 1'b1;
  localparam logic [7:0] TEXT_ATTR_RESET = 8'd10;
  localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_ADVANCE
  } cur_op_e;

  typedef struct packed {
    logic    accept;
    logic    sweep_en;
    logic    sweep_zero_all;
    cur_op_e cur_op;
    logic    cell_we;
    logic    tab_init;
    logic    tab_step;
    logic    tab_load_gap;
    logic    tab_load_one;
    logic    tab_dec;
    logic    set_scrolled;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic func_read;
    logic ch_newline;
    logic ch_backspace;
    logic ch_tab;
    logic col_zero;
    logic last_row;
    logic last_cell;
    logic tab_mod_last;
    logic tab_zero;
    logic tab_one;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/tccw_ram.sv =====
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tccw_ctrl.sv =====
module tccw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tccw_pkg::status_t status_i,
  output tccw_pkg::cmd_t    cmd_o
);

  import tccw_pkg::*;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_CLR_DRAIN = 4'd1;
  localparam logic [3:0] S_IDLE      = 4'd2;
  localparam logic [3:0] S_DECODE    = 4'd3;
  localparam logic [3:0] S_BSW       = 4'd4;
  localparam logic [3:0] S_TABMOD    = 4'd5;
  localparam logic [3:0] S_TABSET    = 4'd6;
  localparam logic [3:0] S_PUT       = 4'd7;
  localparam logic [3:0] S_SCROLL    = 4'd8;
  localparam logic [3:0] S_DRAIN     = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_en       = 1'b1;
        cmd_o.sweep_zero_all = 1'b1;
        if (status_i.sweep_last) state_d = S_CLR_DRAIN;
      end
      S_CLR_DRAIN: begin
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.func_read) begin
          state_d = S_DONE;
        end else if (status_i.ch_newline) begin
          cmd_o.cur_op = CUR_NEWLINE;
          if (status_i.last_row) begin
            cmd_o.set_scrolled = 1'b1;
            state_d            = S_SCROLL;
          end else begin
            state_d = S_DONE;
          end
        end else if (status_i.ch_backspace) begin
          if (!status_i.col_zero) begin
            cmd_o.cur_op = CUR_BACK;
            state_d      = S_BSW;
          end else begin
            state_d = S_DONE;
          end
        end else if (status_i.ch_tab) begin
          cmd_o.tab_init = 1'b1;
          state_d        = S_TABMOD;
        end else begin
          cmd_o.tab_load_one = 1'b1;
          state_d            = S_PUT;
        end
      end
      S_BSW: begin
        cmd_o.cell_we = 1'b1;
        state_d       = S_DONE;
      end
      S_TABMOD: begin
        cmd_o.tab_step = 1'b1;
        if (status_i.tab_mod_last) state_d = S_TABSET;
      end
      S_TABSET: begin
        cmd_o.tab_load_gap = 1'b1;
        state_d            = S_PUT;
      end
      S_PUT: begin
        cmd_o.cell_we = 1'b1;
        cmd_o.cur_op  = CUR_ADVANCE;
        cmd_o.tab_dec = 1'b1;
        if (status_i.last_cell) begin
          cmd_o.set_scrolled = 1'b1;
          state_d            = S_SCROLL;
        end else if (status_i.tab_one) begin
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = status_i.tab_zero ? S_DONE : S_PUT;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/tccw_datapath.sv =====
module tccw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                func_i,
  input  logic [7:0]                          char_code_i,
  input  logic [10:0]                         read_cell_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [4:0]                          cursor_row_o,
  output logic [6:0]                          cursor_col_o,
  output logic                                scrolled_o,
  output logic [7:0]                          read_char_o,
  output logic [7:0]                          read_attr_o,
  input  tccw_pkg::cmd_t                      cmd_i,
  output tccw_pkg::status_t                   status_o
);

  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELLS);
  localparam int BIT_W  = $clog2(COL_W);
  localparam int IDX_W  = ((CELL_W > 11) ? CELL_W : 11) + 1;
  localparam int ROW_X  = (ROW_W > 5) ? ROW_W : 5;
  localparam int COL_X  = (COL_W > 7) ? COL_W : 7;

  localparam logic [CELL_W-1:0] BOTTOM    = CELL_W'(CELLS - COLUMNS);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(COL_W - 1);

  // Configuration
  logic [7:0] attr_q;
  logic [4:0] tab_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q  <= TEXT_ATTR_RESET;
      tab_w_q <= TAB_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEXT_ATTR: attr_q  <= cfg_data_i;
        REG_TAB_WIDTH: tab_w_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Latched item
  logic        func_q;
  logic [7:0]  char_q;
  logic [10:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      char_q <= char_code_i;
      idx_q  <= read_cell_i;
    end
  end

  logic is_nl, is_bs, is_tab;
  assign is_nl  = (char_q == CHAR_NEWLINE);
  assign is_bs  = (char_q == CHAR_BACKSPACE);
  assign is_tab = (char_q == CHAR_TAB);

  // Cursor
  logic [CELL_W-1:0] addr_q, addr_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              at_last_row, at_last_cell;

  assign at_last_row  = (row_q == LAST_ROW);
  assign at_last_cell = (addr_q == LAST_CELL);

  always_comb begin
    addr_d = addr_q;
    row_d  = row_q;
    col_d  = col_q;
    case (cmd_i.cur_op)
      CUR_NEWLINE: begin
        col_d = '0;
        if (at_last_row) begin
          addr_d = BOTTOM;
        end else begin
          addr_d = addr_q + ROW_STEP - CELL_W'(col_q);
          row_d  = row_q + 1'b1;
        end
      end
      CUR_BACK: begin
        addr_d = addr_q - 1'b1;
        col_d  = col_q - 1'b1;
      end
      CUR_ADVANCE: begin
        if (at_last_cell) begin
          addr_d = BOTTOM;
          row_d  = LAST_ROW;
          col_d  = '0;
        end else begin
          addr_d = addr_q + 1'b1;
          if (col_q == LAST_COL) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      addr_q <= addr_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // Tab gap: remainder of column by tab width, one column bit per cycle
  logic [4:0]       tw_eff;
  logic [4:0]       rem_q, rem_d;
  logic [5:0]       rem_sh;
  logic [BIT_W-1:0] bit_q;
  logic [4:0]       tab_n_q;

  assign tw_eff = (tab_w_q == 5'd0) ? 5'd1 : tab_w_q;
  assign rem_sh = {rem_q, col_q[bit_q]};
  assign rem_d  = (rem_sh >= {1'b0, tw_eff}) ? 5'(rem_sh - {1'b0, tw_eff}) : rem_sh[4:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_init) begin
      rem_q <= '0;
    end else if (cmd_i.tab_step) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q   <= '0;
      tab_n_q <= '0;
    end else begin
      if (cmd_i.tab_init) begin
        bit_q <= TOP_BIT;
      end else if (cmd_i.tab_step) begin
        bit_q <= bit_q - 1'b1;
      end
      if (cmd_i.accept) begin
        tab_n_q <= '0;
      end else if (cmd_i.tab_load_one) begin
        tab_n_q <= 5'd1;
      end else if (cmd_i.tab_load_gap) begin
        tab_n_q <= tw_eff - rem_q;
      end else if (cmd_i.tab_dec) begin
        tab_n_q <= tab_n_q - 1'b1;
      end
    end
  end

  // Sweep over the store: copy each cell from one row below, or zero it
  logic [CELL_W-1:0] sw_q;
  logic              sw_last;
  logic              wr_v_q, wr_z_q;
  logic [CELL_W-1:0] wr_a_q;

  assign sw_last = (sw_q == LAST_CELL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= '0;
      wr_v_q <= 1'b0;
    end else begin
      wr_v_q <= cmd_i.sweep_en;
      if (cmd_i.sweep_en && !sw_last) begin
        sw_q <= sw_q + 1'b1;
      end else begin
        sw_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_a_q <= sw_q;
    wr_z_q <= cmd_i.sweep_zero_all || (sw_q >= BOTTOM);
  end

  // Cell store
  logic [IDX_W-1:0]  idx_w;
  logic              in_range;
  logic [CELL_W-1:0] raddr, waddr;
  logic [15:0]       rdata, wdata;
  logic              we;
  logic [7:0]        wchar;

  assign idx_w    = IDX_W'(idx_q);
  assign in_range = (idx_w < IDX_W'(CELLS));
  assign raddr    = cmd_i.sweep_en ? (sw_q + ROW_STEP) : idx_w[CELL_W-1:0];
  assign wchar    = (is_bs || is_tab) ? CHAR_SPACE : char_q;
  assign we       = wr_v_q || cmd_i.cell_we;
  assign waddr    = wr_v_q ? wr_a_q : addr_q;
  assign wdata    = wr_v_q ? (wr_z_q ? 16'h0000 : rdata) : {attr_q, wchar};

  tccw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Result register
  logic             scr_q;
  logic             out_valid_q;
  logic [ROW_X-1:0] row_x;
  logic [COL_X-1:0] col_x;
  logic [4:0]       out_row_q;
  logic [6:0]       out_col_q;
  logic             out_scr_q;
  logic [15:0]      out_cell_q;

  assign row_x = ROW_X'(row_q);
  assign col_x = COL_X'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        scr_q <= 1'b0;
      end else if (cmd_i.set_scrolled) begin
        scr_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= row_x[4:0];
      out_col_q  <= col_x[6:0];
      out_scr_q  <= scr_q;
      out_cell_q <= ((func_q == FUNC_READ) && in_range) ? rdata : 16'h0000;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;
  assign read_char_o  = out_cell_q[7:0];
  assign read_attr_o  = out_cell_q[15:8];

  // Status to the controller
  always_comb begin
    status_o              = '0;
    status_o.func_read    = (func_q == FUNC_READ);
    status_o.ch_newline   = is_nl;
    status_o.ch_backspace = is_bs;
    status_o.ch_tab       = is_tab;
    status_o.col_zero     = (col_q == '0);
    status_o.last_row     = at_last_row;
    status_o.last_cell    = at_last_cell;
    status_o.tab_mod_last = (bit_q == '0);
    status_o.tab_zero     = (tab_n_q == 5'd0);
    status_o.tab_one      = (tab_n_q == 5'd1);
    status_o.sweep_last   = sw_last;
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Text console writer: a COLUMNS x ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor.
// Input channel (in_valid_i / in_stall_o): one transfer carries func_i, char_code_i
// and read_cell_i. func_i selects a character put or a read of one cell.
// Output channel (out_valid_o / out_stall_i): one transfer per input item with the
// cursor position after the item, the scroll flag and the read cell bytes.
// A read, a newline without scroll or a backspace at column zero goes from decode
// straight to the result; a plain character or a backspace first writes one cell,
// and a tab writing n spaces first computes the tab-stop remainder one column bit
// per cycle, then writes one cell per cycle unless a scroll intervenes. A scroll
// sweeps the store: the row copy moves one cell per cycle through the single store
// write port. A new item is taken only once the last one's result is loaded.
// Reset clears the cursor, restores text_attr and tab_width, and starts a
// clearing pass that zeroes the store; in_stall_o stays high until it finishes.
// Configuration writes go through cfg_we_i at any time.
// A finished result waits in the output register while the receiver stalls; the
// next item is taken meanwhile and held in its last step until the output frees.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [7:0]                      char_code_i,
  input  logic [10:0]                     read_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [4:0]                      cursor_row_o,
  output logic [6:0]                      cursor_col_o,
  output logic                            scrolled_o,
  output logic [7:0]                      read_char_o,
  output logic [7:0]                      read_attr_o
);

  import tccw_pkg::*;

  // Commands from the sequencer, status back from the datapath
  cmd_t    cmd;
  status_t status;

  // Sequencer: clearing pass, item decode, tab gap, cell writes, scroll sweep
  tccw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: config registers, cursor, cell store, result register
  tccw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .read_cell_i (read_cell_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .scrolled_o  (scrolled_o),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
